>>> hdl/glyph_blit_to_dot_buffer_core_assert.svh
// ----------------------------------------------------------------------------
// glyph blit assertion macros
// shared concurrent assertion forms, clocked on i_clk, quiet in reset
// ----------------------------------------------------------------------------
`ifndef GLYPH_BLIT_TO_DOT_BUFFER_CORE_ASSERT_SVH
`define GLYPH_BLIT_TO_DOT_BUFFER_CORE_ASSERT_SVH

// same-cycle implication
`define GBDB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define GBDB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/gbdb_pkg.sv
// ----------------------------------------------------------------------------
// gbdb_pkg
// types, codes and constants of the glyph blit core
// ----------------------------------------------------------------------------
package gbdb_pkg;

    localparam int DEF_LINE_DOTS = 384;
    localparam int DEF_MAX_LINES = 1024;
    localparam int WORD_BITS     = 64;
    localparam int OFF_W         = 6;
    localparam int WIDE_W        = 13;

    localparam int X_W    = 11;
    localparam int Y_W    = 12;
    localparam int ROW_W  = 7;
    localparam int GW_W   = 7;

    localparam logic [X_W-1:0]   X_MAX   = '1;
    localparam logic [Y_W-1:0]   Y_MAX   = '1;
    localparam logic [ROW_W-1:0] ROW_MAX = '1;
    localparam logic [GW_W-1:0]  GW_MAX  = 7'd64;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_MARGIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_MARGIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CHAR_SPACE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_SPACE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FONT_HEIGHT  = 3'd6;

    localparam logic [2:0] CMD_GLYPH_ROW = 3'd0;
    localparam logic [2:0] CMD_NEWLINE   = 3'd1;
    localparam logic [2:0] CMD_CTRL_ADV  = 3'd2;
    localparam logic [2:0] CMD_END_TEXT  = 3'd3;
    localparam logic [2:0] CMD_READ_WORD = 3'd4;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WORD0,
        ST_WORD1,
        ST_HOLD
    } t_state;

    typedef struct packed {
        logic [2:0]           command;
        logic [WORD_BITS-1:0] row_bits;
        logic [GW_W-1:0]      glyph_width;
        logic                 last_row;
        logic [9:0]           read_line;
        logic [2:0]           read_word;
    } t_in_beat;

    typedef struct packed {
        logic [WORD_BITS-1:0] read_data;
        logic [X_W-1:0]       cursor_x;
        logic [Y_W-1:0]       cursor_y;
        logic [Y_W-1:0]       used_lines;
        logic                 row_clipped;
    } t_out_beat;

endpackage

>>> hdl/gbdb_ram.sv
// ----------------------------------------------------------------------------
// gbdb_ram
// generic simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module gbdb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/gbdb_row_merge.sv
// ----------------------------------------------------------------------------
// gbdb_row_merge
// aligns a glyph row to its dot offset and merges it into one store word
// ----------------------------------------------------------------------------
module gbdb_row_merge
    import gbdb_pkg::*;
(
    input  logic [WORD_BITS-1:0] i_bits,
    input  logic [GW_W-1:0]      i_draw,
    input  logic [OFF_W-1:0]     i_off,
    input  logic                 i_second,
    input  logic [WORD_BITS-1:0] i_old,
    output logic [WORD_BITS-1:0] o_word
);

    logic [WORD_BITS-1:0]   dmask;
    logic [2*WORD_BITS-1:0] mask_wide;
    logic [2*WORD_BITS-1:0] data_wide;
    logic [WORD_BITS-1:0]   mask_sel;
    logic [WORD_BITS-1:0]   data_sel;

    always_comb begin
        dmask     = ~({WORD_BITS{1'b1}} >> i_draw);
        mask_wide = {dmask, {WORD_BITS{1'b0}}} >> i_off;
        data_wide = {i_bits & dmask, {WORD_BITS{1'b0}}} >> i_off;
        if (i_second) begin
            mask_sel = mask_wide[WORD_BITS-1:0];
            data_sel = data_wide[WORD_BITS-1:0];
        end else begin
            mask_sel = mask_wide[2*WORD_BITS-1:WORD_BITS];
            data_sel = data_wide[2*WORD_BITS-1:WORD_BITS];
        end
        o_word = (i_old & ~mask_sel) | data_sel;
    end

endmodule

>>> hdl/glyph_blit_to_dot_buffer_core.sv
// ----------------------------------------------------------------------------
// glyph_blit_to_dot_buffer_core
// glyph row blitter into a one-bit-per-dot page store with text cursor
// ----------------------------------------------------------------------------
// One beat in gives one beat out. After reset the page store is swept to zero,
// one word a cycle, all MAX_LINES * ceil(LINE_DOTS / 64) words (6144 at the
// default sizes); no beat is taken during the sweep, configuration writes are.
// A beat is accepted in ST_IDLE with the store read issued; ST_WORD0 does the
// read-modify-write of the first store word and, unless the row straddles two
// words, puts the result into the output register. A straddling row does the
// second word and the result in ST_WORD1, as the store has one write port. A
// pending register lets a beat finish while the output register still holds
// the previous result; a further beat waits until the output register frees.
module glyph_blit_to_dot_buffer_core
    import gbdb_pkg::*;
#(
    parameter int LINE_DOTS = DEF_LINE_DOTS,
    parameter int MAX_LINES = DEF_MAX_LINES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_beat              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_beat             o_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int WPL    = (LINE_DOTS + WORD_BITS - 1) / WORD_BITS;
    localparam int DEPTH  = MAX_LINES * WPL;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int LINE_W = $clog2(MAX_LINES);
    localparam int WIDX_W = (WPL > 1) ? $clog2(WPL) : 1;

    // configuration
    logic [8:0]       r_cfg_page_width;
    logic [10:0]      r_cfg_page_height;
    logic [6:0]       r_cfg_lmargin;
    logic [6:0]       r_cfg_rmargin;
    logic [7:0]       r_cfg_char_space;
    logic [7:0]       r_cfg_line_space;
    logic [6:0]       r_cfg_font_height;

    // cursor state
    logic [X_W-1:0]   r_pos_x,    n_pos_x;
    logic [Y_W-1:0]   r_pos_y,    n_pos_y;
    logic [ROW_W-1:0] r_row_idx,  n_row_idx;
    logic [Y_W-1:0]   r_lines,    n_lines;

    t_state           r_state,    n_state;
    logic [ADDR_W-1:0] r_clr_addr;

    // captured beat
    logic [2:0]           r_cmd;
    logic [WORD_BITS-1:0] r_bits;
    logic [GW_W-1:0]      r_gw;
    logic                 r_last;
    logic [GW_W-1:0]      r_draw;
    logic [OFF_W-1:0]     r_off;
    logic [ADDR_W-1:0]    r_addr0;
    logic                 r_two;
    logic                 r_active;
    logic                 r_clip;
    logic                 r_rd_ok;

    // output side
    t_out_beat        r_out,  n_out;
    t_out_beat        r_pend;
    logic             r_out_valid, n_out_valid;
    t_out_beat        res;

    // store port
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [WORD_BITS-1:0] ram_q;
    logic [WORD_BITS-1:0] merged;

    // accept-cycle decode
    logic              in_acc;
    logic              slot_free;
    logic              finish;
    logic              need_w1;
    logic [WIDE_W-1:0] page_w;
    logic [WIDE_W-1:0] page_h;
    logic [WIDE_W-1:0] x_used;
    logic [WIDE_W-1:0] avail;
    logic [GW_W-1:0]   gw_c;
    logic [GW_W-1:0]   draw;
    logic [WIDE_W-1:0] line;
    logic              line_ok;
    logic [ADDR_W-1:0] addr0;
    logic              two;
    logic              rd_ok;
    logic [ADDR_W-1:0] rd_addr;
    logic [WIDE_W-1:0] sum_x;
    logic [WIDE_W-1:0] sum_y;

    assign in_acc    = i_in_valid && o_in_ready;
    assign slot_free = !r_out_valid || i_out_ready;
    assign need_w1   = r_two && r_active;
    assign finish    = ((r_state == ST_WORD0) && !need_w1) || (r_state == ST_WORD1);

    always_comb begin
        page_w = (WIDE_W'(r_cfg_page_width) < WIDE_W'(LINE_DOTS))
               ? WIDE_W'(r_cfg_page_width) : WIDE_W'(LINE_DOTS);
        page_h = (WIDE_W'(r_cfg_page_height) < WIDE_W'(MAX_LINES))
               ? WIDE_W'(r_cfg_page_height) : WIDE_W'(MAX_LINES);
        x_used = WIDE_W'(r_pos_x) + WIDE_W'(r_cfg_rmargin);
        avail  = (page_w > x_used) ? (page_w - x_used) : '0;
        gw_c   = (i_in_data.glyph_width > GW_MAX) ? GW_MAX : i_in_data.glyph_width;
        draw   = (WIDE_W'(gw_c) < avail) ? gw_c : avail[GW_W-1:0];
        line   = WIDE_W'(r_pos_y) + WIDE_W'(r_row_idx);
        line_ok = line < page_h;
        addr0  = ADDR_W'(line[LINE_W-1:0] * WPL)
               + ADDR_W'(WIDX_W'(r_pos_x >> OFF_W));
        two    = (8'(r_pos_x[OFF_W-1:0]) + 8'(draw)) > 8'(WORD_BITS);
        rd_ok  = (WIDE_W'(i_in_data.read_line) < WIDE_W'(MAX_LINES))
              && (6'(i_in_data.read_word) < 6'(WPL));
        rd_addr = ADDR_W'(LINE_W'(i_in_data.read_line) * WPL)
                + ADDR_W'(WIDX_W'(i_in_data.read_word));
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd    <= i_in_data.command;
            r_bits   <= i_in_data.row_bits;
            r_gw     <= gw_c;
            r_last   <= i_in_data.last_row;
            r_draw   <= draw;
            r_off    <= r_pos_x[OFF_W-1:0];
            r_addr0  <= addr0;
            r_two    <= two;
            r_active <= (i_in_data.command == CMD_GLYPH_ROW) && (gw_c != '0)
                        && line_ok && (draw != '0);
            r_clip   <= (i_in_data.command == CMD_GLYPH_ROW) && (gw_c != '0)
                        && (!line_ok || (draw < gw_c));
            r_rd_ok  <= rd_ok;
        end
    end

    gbdb_row_merge u_merge (
        .i_bits   (r_bits),
        .i_draw   (r_draw),
        .i_off    (r_off),
        .i_second (r_state == ST_WORD1),
        .i_old    (ram_q),
        .o_word   (merged)
    );

    gbdb_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == ADDR_W'(DEPTH - 1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (in_acc) n_state = ST_WORD0;
            end
            ST_WORD0: begin
                if (need_w1)        n_state = ST_WORD1;
                else if (slot_free) n_state = ST_IDLE;
                else                n_state = ST_HOLD;
            end
            ST_WORD1: begin
                n_state = slot_free ? ST_IDLE : ST_HOLD;
            end
            ST_HOLD: begin
                if (slot_free) n_state = ST_IDLE;
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // fsm outputs
    always_comb begin
        o_in_ready = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = r_addr0;
        ram_wdata  = merged;
        ram_raddr  = r_addr0;
        unique case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_addr;
                ram_wdata = '0;
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                ram_raddr  = (i_in_data.command == CMD_READ_WORD) ? rd_addr : addr0;
            end
            ST_WORD0: begin
                ram_we    = r_active;
                ram_raddr = r_addr0 + ADDR_W'(1);
            end
            ST_WORD1: begin
                ram_we    = r_active;
                ram_waddr = r_addr0 + ADDR_W'(1);
            end
            ST_HOLD: begin
                ram_we = 1'b0;
            end
            default: ram_we = 1'b0;
        endcase
    end

    // cursor update at the end of a beat, and on a left margin write at column zero
    always_comb begin
        n_pos_x   = r_pos_x;
        n_pos_y   = r_pos_y;
        n_row_idx = r_row_idx;
        n_lines   = r_lines;
        sum_x     = '0;
        sum_y     = '0;
        if (finish) begin
            unique case (r_cmd)
                CMD_GLYPH_ROW: begin
                    sum_x = WIDE_W'(r_pos_x) + WIDE_W'(r_gw) + WIDE_W'(r_cfg_char_space);
                    if (r_last) begin
                        n_pos_x   = (sum_x > WIDE_W'(X_MAX)) ? X_MAX : sum_x[X_W-1:0];
                        n_row_idx = '0;
                    end else if (r_row_idx != ROW_MAX) begin
                        n_row_idx = r_row_idx + ROW_W'(1);
                    end
                end
                CMD_NEWLINE: begin
                    sum_y = WIDE_W'(r_pos_y) + WIDE_W'(r_cfg_font_height)
                          + WIDE_W'(r_cfg_line_space);
                    n_pos_y   = (sum_y > WIDE_W'(Y_MAX)) ? Y_MAX : sum_y[Y_W-1:0];
                    n_pos_x   = X_W'(r_cfg_lmargin);
                    n_row_idx = '0;
                end
                CMD_CTRL_ADV: begin
                    sum_x = WIDE_W'(r_pos_x) + WIDE_W'(r_cfg_char_space)
                          + WIDE_W'(r_cfg_font_height >> 1);
                    n_pos_x   = (sum_x > WIDE_W'(X_MAX)) ? X_MAX : sum_x[X_W-1:0];
                    n_row_idx = '0;
                end
                CMD_END_TEXT: begin
                    sum_y = WIDE_W'(r_pos_y) + WIDE_W'(r_cfg_font_height);
                    if (WIDE_W'(r_lines) < sum_y) begin
                        n_lines = (sum_y > WIDE_W'(Y_MAX)) ? Y_MAX : sum_y[Y_W-1:0];
                    end
                    n_row_idx = '0;
                end
                default: begin
                    n_row_idx = r_row_idx;
                end
            endcase
        end
        if (i_cfg_we && (i_cfg_index == CFG_LEFT_MARGIN) && (r_pos_x == '0)) begin
            n_pos_x = X_W'(i_cfg_data[6:0]);
        end
    end

    // result beat
    always_comb begin
        res.read_data   = ((r_cmd == CMD_READ_WORD) && r_rd_ok) ? ram_q : '0;
        res.cursor_x    = n_pos_x;
        res.cursor_y    = n_pos_y;
        res.used_lines  = n_lines;
        res.row_clipped = r_clip;

        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        if (finish && slot_free) begin
            n_out       = res;
            n_out_valid = 1'b1;
        end else if ((r_state == ST_HOLD) && slot_free) begin
            n_out       = r_pend;
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (finish && !slot_free) begin
            r_pend <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state           <= ST_CLEAR;
            r_clr_addr        <= '0;
            r_out_valid       <= 1'b0;
            r_pos_x           <= '0;
            r_pos_y           <= '0;
            r_row_idx         <= '0;
            r_lines           <= '0;
            r_cfg_page_width  <= 9'd384;
            r_cfg_page_height <= 11'd1024;
            r_cfg_lmargin     <= '0;
            r_cfg_rmargin     <= '0;
            r_cfg_char_space  <= '0;
            r_cfg_line_space  <= '0;
            r_cfg_font_height <= 7'd24;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_pos_x     <= n_pos_x;
            r_pos_y     <= n_pos_y;
            r_row_idx   <= n_row_idx;
            r_lines     <= n_lines;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_PAGE_WIDTH:   r_cfg_page_width  <= i_cfg_data[8:0];
                    CFG_PAGE_HEIGHT:  r_cfg_page_height <= i_cfg_data[10:0];
                    CFG_LEFT_MARGIN:  r_cfg_lmargin     <= i_cfg_data[6:0];
                    CFG_RIGHT_MARGIN: r_cfg_rmargin     <= i_cfg_data[6:0];
                    CFG_CHAR_SPACE:   r_cfg_char_space  <= i_cfg_data[7:0];
                    CFG_LINE_SPACE:   r_cfg_line_space  <= i_cfg_data[7:0];
                    CFG_FONT_HEIGHT:  r_cfg_font_height <= i_cfg_data[6:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`include "glyph_blit_to_dot_buffer_core_assert.svh"

    `GBDB_ASSERT_NOW(a_no_write_idle, (r_state == ST_IDLE) || (r_state == ST_HOLD), !ram_we, "store written outside a beat or the sweep")
    `GBDB_ASSERT_NOW(a_word1_after_word0, r_state == ST_WORD1, $past(r_state) == ST_WORD0, "second word without first word")
    `GBDB_ASSERT_NOW(a_hold_has_result, r_state == ST_HOLD, r_out_valid, "pending result with empty output register")
    `GBDB_ASSERT_NEXT(a_hold_drains, (r_state == ST_HOLD) && slot_free, r_out_valid && (r_state == ST_IDLE), "pending result not moved out")

endmodule

>>> tb/glyph_blit_to_dot_buffer_core_tb.sv
// ----------------------------------------------------------------------------
// glyph_blit_to_dot_buffer_core_tb
// self-checking bench: a page model tracks the dot store, cursor, row counter
// and used lines for every accepted beat and checks each result beat in order,
// across several page settings, with random idling on both channels
// ----------------------------------------------------------------------------
module glyph_blit_to_dot_buffer_core_tb;
    import gbdb_pkg::*;

    localparam int WORDS_PER_LINE = (DEF_LINE_DOTS + WORD_BITS - 1) / WORD_BITS;
    localparam int STORE_WORDS    = DEF_MAX_LINES * WORDS_PER_LINE;
    localparam int CYCLE_LIMIT    = 1000000;
    localparam int HOLD_CYCLES    = 300;
    localparam int RANDOM_BEATS   = 1950;
    localparam int N_REGS         = 7;
    localparam int N_SETUPS       = 9;
    localparam logic [2:0] CMD_LAST_CODE = '1;

    // page_width, page_height, left_margin, right_margin, char_space, line_space, font_height
    localparam int SETUPS [N_SETUPS][N_REGS] = '{
        '{384, 1024,   0,   0,   0,   0,  24},
        '{384, 1024,   5,   3,   1,   0,   8},
        '{  8, 1024,   0,   0,   0,   0,   0},
        '{511, 2047, 100,   0,   2,   1,   8},
        '{200, 1024, 127, 127,   0,   0,   8},
        '{384,  600,   0, 100, 255,   0,  16},
        '{  0,    1,  17,   5,   3,   2,   9},
        '{384, 1024,   0,   0,   1,   0,  12},
        '{384, 1024,  33,   0, 255, 255, 127}
    };
    localparam logic [CFG_IDX_W-1:0] REG_ORDER [N_REGS] = '{
        CFG_PAGE_WIDTH, CFG_PAGE_HEIGHT, CFG_LEFT_MARGIN, CFG_RIGHT_MARGIN,
        CFG_CHAR_SPACE, CFG_LINE_SPACE, CFG_FONT_HEIGHT
    };

    typedef enum int {IDLE_NONE, IDLE_LIGHT, IDLE_HEAVY} t_idle;

    class dot_page_model;
        logic [WORD_BITS-1:0] dots [STORE_WORDS];
        int page_w, page_h, lmargin, rmargin, cspace, lspace, font_h;
        int cur_x, cur_y, row_idx, lines_used;
        int errors;
        t_out_beat expected_beats [$];

        function new();
            foreach (dots[i]) dots[i] = '0;
            page_w = DEF_LINE_DOTS;
            page_h = DEF_MAX_LINES;
            lmargin = 0;
            rmargin = 0;
            cspace = 0;
            lspace = 0;
            font_h = 24;
            cur_x = 0;
            cur_y = 0;
            row_idx = 0;
            lines_used = 0;
            errors = 0;
        endfunction

        function int sat(int v, int lim);
            return v > lim ? lim : v;
        endfunction

        function int eff_width();
            return page_w < DEF_LINE_DOTS ? page_w : DEF_LINE_DOTS;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, int v);
            case (idx)
                CFG_PAGE_WIDTH:   page_w = v & 'h1FF;
                CFG_PAGE_HEIGHT:  page_h = v & 'h7FF;
                CFG_LEFT_MARGIN: begin
                    lmargin = v & 'h7F;
                    if (cur_x == 0) cur_x = lmargin;
                end
                CFG_RIGHT_MARGIN: rmargin = v & 'h7F;
                CFG_CHAR_SPACE:   cspace = v & 'hFF;
                CFG_LINE_SPACE:   lspace = v & 'hFF;
                CFG_FONT_HEIGHT:  font_h = v & 'h7F;
                default: ;
            endcase
        endfunction

        function logic blit_row(logic [WORD_BITS-1:0] bits, int gw, logic last);
            int ph, line, avail, draw, x;
            logic cut;
            ph = page_h < DEF_MAX_LINES ? page_h : DEF_MAX_LINES;
            line = cur_y + row_idx;
            cut = 1'b0;
            if (gw > WORD_BITS) gw = WORD_BITS;
            avail = eff_width() > cur_x + rmargin ? eff_width() - cur_x - rmargin : 0;
            draw = gw < avail ? gw : avail;
            if (gw > 0) begin
                if (line >= ph) begin
                    cut = 1'b1;
                end else begin
                    cut = draw < gw;
                    for (int i = 0; i < draw; i++) begin
                        x = cur_x + i;
                        dots[line * WORDS_PER_LINE + x / WORD_BITS][WORD_BITS - 1 - x % WORD_BITS]
                            = bits[WORD_BITS - 1 - i];
                    end
                end
            end
            if (last) begin
                cur_x = sat(cur_x + gw + cspace, int'(X_MAX));
                row_idx = 0;
            end else if (row_idx < int'(ROW_MAX)) begin
                row_idx++;
            end
            return cut;
        endfunction

        function void take_beat(t_in_beat b);
            t_out_beat e;
            int bottom;
            e = '0;
            case (b.command)
                CMD_GLYPH_ROW: begin
                    e.row_clipped = blit_row(b.row_bits, int'(b.glyph_width), b.last_row);
                end
                CMD_NEWLINE: begin
                    cur_y = sat(cur_y + font_h + lspace, int'(Y_MAX));
                    cur_x = lmargin;
                    row_idx = 0;
                end
                CMD_CTRL_ADV: begin
                    cur_x = sat(cur_x + cspace + font_h / 2, int'(X_MAX));
                    row_idx = 0;
                end
                CMD_END_TEXT: begin
                    bottom = sat(cur_y + font_h, int'(Y_MAX));
                    if (lines_used < bottom) lines_used = bottom;
                    row_idx = 0;
                end
                CMD_READ_WORD: begin
                    if (b.read_line < DEF_MAX_LINES && b.read_word < WORDS_PER_LINE)
                        e.read_data = dots[b.read_line * WORDS_PER_LINE + b.read_word];
                end
                default: ;
            endcase
            e.cursor_x = X_W'(cur_x);
            e.cursor_y = Y_W'(cur_y);
            e.used_lines = Y_W'(lines_used);
            expected_beats.push_back(e);
        endfunction

        function void check_beat(t_out_beat got);
            t_out_beat e;
            if (expected_beats.size() == 0) begin
                $error("result beat with nothing expected: %h", got);
                errors++;
                return;
            end
            e = expected_beats.pop_front();
            if (got.read_data !== e.read_data) begin
                $error("read_data: expected %h, actual %h", e.read_data, got.read_data);
                errors++;
            end
            if (got.cursor_x !== e.cursor_x) begin
                $error("cursor_x: expected %0d, actual %0d", e.cursor_x, got.cursor_x);
                errors++;
            end
            if (got.cursor_y !== e.cursor_y) begin
                $error("cursor_y: expected %0d, actual %0d", e.cursor_y, got.cursor_y);
                errors++;
            end
            if (got.used_lines !== e.used_lines) begin
                $error("used_lines: expected %0d, actual %0d", e.used_lines, got.used_lines);
                errors++;
            end
            if (got.row_clipped !== e.row_clipped) begin
                $error("row_clipped: expected %0b, actual %0b", e.row_clipped, got.row_clipped);
                errors++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    t_in_beat              in_data;
    logic                  out_valid;
    logic                  out_ready;
    t_out_beat             out_data;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    dot_page_model page;
    t_idle         send_mode;
    t_idle         recv_mode;
    logic          hold_off;
    int            beats_sent;
    int            cycles = 0;

    glyph_blit_to_dot_buffer_core u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic int draw_gap(t_idle mode);
        case (mode)
            IDLE_LIGHT: return $urandom_range(0, 3) == 0 ? $urandom_range(1, 16) : 0;
            IDLE_HEAVY: return $urandom_range(0, 16);
            default:    return 0;
        endcase
    endfunction

    function automatic logic [WORD_BITS-1:0] rand_bits();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic t_in_beat mk(logic [2:0] cmd, logic [WORD_BITS-1:0] bits, int gw,
                                    logic last, int rline, int rword);
        t_in_beat b;
        b.command = cmd;
        b.row_bits = bits;
        b.glyph_width = gw[GW_W-1:0];
        b.last_row = last;
        b.read_line = rline[9:0];
        b.read_word = rword[2:0];
        return b;
    endfunction

    function automatic t_in_beat any_beat(logic [2:0] cmd);
        return mk(cmd, rand_bits(), $urandom_range(0, 127), 1'($urandom_range(0, 1)),
                  $urandom_range(0, 1023), $urandom_range(0, 7));
    endfunction

    // entered and left at a falling edge
    task automatic send_beat(t_in_beat b);
        int gap;
        gap = draw_gap(send_mode);
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_data = b;
        in_valid = 1'b1;
        do @(posedge clk); while (!in_ready);
        page.take_beat(b);
        beats_sent++;
        @(negedge clk);
    endtask

    task automatic set_reg(logic [CFG_IDX_W-1:0] idx, int v);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = v[CFG_DATA_W-1:0];
        @(negedge clk);
        page.write_reg(idx, v);
        cfg_we = 1'b0;
    endtask

    // wait for every result, then let a straddling write finish
    task automatic settle();
        in_valid = 1'b0;
        while (page.expected_beats.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic send_glyph(int rows, int gw, logic broken);
        int word;
        if (page.cur_x + (gw > WORD_BITS ? WORD_BITS : gw) + page.rmargin > page.eff_width()
            && $urandom_range(0, 1) == 1) begin
            send_beat(any_beat(CMD_NEWLINE));
        end
        for (int r = 0; r < rows; r++) begin
            send_beat(mk(CMD_GLYPH_ROW, rand_bits(), gw, r == rows - 1 && !broken,
                         $urandom_range(0, 1023), $urandom_range(0, 7)));
            if ($urandom_range(0, 4) == 0) begin
                word = page.cur_x / WORD_BITS - int'($urandom_range(0, 1));
                send_beat(mk(CMD_READ_WORD, rand_bits(), $urandom_range(0, 127),
                             1'($urandom_range(0, 1)),
                             page.cur_y + int'($urandom_range(0, rows)), word));
            end
        end
    endtask

    task automatic text_run(int stop_at);
        int pick, gw;
        while (beats_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 62) begin
                case ($urandom_range(0, 9))
                    0:       gw = 0;
                    1:       gw = $urandom_range(25, 127);
                    default: gw = $urandom_range(1, 24);
                endcase
                send_glyph($urandom_range(0, 99) == 0 ? 130 : $urandom_range(1, 12), gw,
                           $urandom_range(0, 19) == 0);
            end else if (pick < 67) begin
                send_beat(any_beat(CMD_NEWLINE));
            end else if (pick < 73) begin
                send_beat(any_beat(CMD_CTRL_ADV));
            end else if (pick < 78) begin
                send_beat(any_beat(CMD_END_TEXT));
            end else if (pick < 95) begin
                send_beat(mk(CMD_READ_WORD, rand_bits(), $urandom_range(0, 127),
                             1'($urandom_range(0, 1)),
                             $urandom_range(0, 1) ? page.cur_y + int'($urandom_range(0, 15))
                                                  : int'($urandom_range(0, 1023)),
                             $urandom_range(0, 7)));
            end else begin
                send_beat(any_beat(3'($urandom_range(CMD_READ_WORD + 1, CMD_LAST_CODE))));
            end
        end
    endtask

    // result side
    initial begin
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever begin
            stall = hold_off ? HOLD_CYCLES : draw_gap(recv_mode);
            hold_off = 1'b0;
            if (stall > 0) begin
                out_ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready = 1'b1;
            do @(posedge clk); while (!out_valid);
            page.check_beat(out_data);
            @(negedge clk);
        end
    end

    initial begin
        page = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        send_mode = IDLE_NONE;
        recv_mode = IDLE_NONE;
        hold_off = 1'b0;
        beats_sent = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int p = 0; p < N_SETUPS; p++) begin
            if (p > 0) settle();
            for (int r = 0; r < N_REGS; r++) set_reg(REG_ORDER[r], SETUPS[p][r]);
            send_mode = t_idle'(p % 3);
            recv_mode = t_idle'((p + 2) % 3);
            if (p == 0) begin
                // full-word row, wide glyph, word straddle, zero width, single dot
                send_beat(mk(CMD_GLYPH_ROW, '1, WORD_BITS, 1'b0, 0, 0));
                send_beat(mk(CMD_GLYPH_ROW, 64'hA5A5_5A5A_C3C3_3C3C, WORD_BITS, 1'b1, 0, 0));
                send_beat(mk(CMD_GLYPH_ROW, 64'hF0F0_0F0F_FF00_00FF, 127, 1'b1, 0, 0));
                send_beat(any_beat(CMD_CTRL_ADV));
                send_beat(mk(CMD_GLYPH_ROW, {$urandom, $urandom}, WORD_BITS, 1'b1, 0, 0));
                send_beat(mk(CMD_GLYPH_ROW, '1, 0, 1'b1, 0, 0));
                send_beat(mk(CMD_GLYPH_ROW, 64'h8000_0000_0000_0001, 1, 1'b0, 0, 0));
                for (int w = 0; w < 4; w++) send_beat(mk(CMD_READ_WORD, '0, 0, 1'b0, 0, w));
                send_beat(mk(CMD_READ_WORD, '1, 127, 1'b1, 1, 0));
                send_beat(mk(CMD_READ_WORD, '0, 0, 1'b0, 0, WORDS_PER_LINE));
                send_beat(mk(CMD_READ_WORD, '0, 0, 1'b0, DEF_MAX_LINES - 1, WORDS_PER_LINE + 1));
                send_beat(mk(CMD_READ_WORD, '1, 0, 1'b0, DEF_MAX_LINES - 1, WORDS_PER_LINE - 1));
                for (logic [3:0] c = 4'(CMD_READ_WORD) + 4'd1; c <= 4'(CMD_LAST_CODE); c++)
                    send_beat(any_beat(c[2:0]));
                send_beat(any_beat(CMD_END_TEXT));
                send_beat(any_beat(CMD_NEWLINE));
                send_beat(mk(CMD_READ_WORD, '0, 0, 1'b0, 1, 1));
            end
            if (p == 1) begin
                // long result stall while beats keep coming, with a glyph taller than the counter
                send_mode = IDLE_NONE;
                hold_off = 1'b1;
                send_glyph(130, 8, 1'b0);
            end
            if (p < N_SETUPS - 1) begin
                text_run(beats_sent + RANDOM_BEATS / (N_SETUPS - 1));
            end else begin
                // drive cursor and used lines into saturation
                repeat (7) send_beat(any_beat(CMD_CTRL_ADV));
                send_beat(mk(CMD_GLYPH_ROW, '1, WORD_BITS, 1'b1, 0, 0));
                repeat (12) send_beat(any_beat(CMD_NEWLINE));
                send_beat(any_beat(CMD_END_TEXT));
                send_beat(mk(CMD_GLYPH_ROW, '1, 9, 1'b1, 0, 0));
                send_beat(any_beat(CMD_READ_WORD));
            end
        end

        settle();
        repeat (16) @(negedge clk);
        if (page.errors == 0 && page.expected_beats.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+hdl
hdl/gbdb_pkg.sv
hdl/gbdb_ram.sv
hdl/gbdb_row_merge.sv
hdl/glyph_blit_to_dot_buffer_core.sv
tb/glyph_blit_to_dot_buffer_core_tb.sv
